// File: rtl/heightmap_vertex_normal_stream_assert.svh
// Assertion macros used by heightmap_vertex_normal_stream.sv.
`ifndef HEIGHTMAP_VERTEX_NORMAL_STREAM_ASSERT_SVH
`define HEIGHTMAP_VERTEX_NORMAL_STREAM_ASSERT_SVH

`ifndef ASSERT_OFF
`define HVN_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define HVN_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define HVN_ASSERT(name, prop, msg)
`define HVN_NEVER(name, expr, msg)
`endif

`endif

// File: rtl/hvn_pkg.sv
`timescale 1ns / 1ps
package hvn_pkg;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam int RW   = 28;   // remainder of the shared step unit
	localparam int QW   = 26;   // quotient / root
	localparam int DW   = 26;   // divisor
	localparam int SW   = 52;   // radicand and shift-in bits
	localparam int NW   = 40;   // dividend
	localparam int MW   = 25;   // multiplier operand
	localparam int PW   = 50;   // product
	localparam int CNTW = 5;

	localparam int SQRT_STEPS = SW / 2;
	localparam int NORM_QB    = 15;
	localparam int WIDE_QB    = 16;
	localparam int NORM_SHIFT = 14;
	localparam int TEX_SHIFT  = 15;
	localparam int SCALE_Y    = 510;
	localparam int HEIGHT_DIV = 255;
	localparam logic [14:0] NORM_ONE = 15'd16384;

	localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd256;
	localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd256;
	localparam logic [15:0] RST_MAX_HEIGHT   = 16'd256;
	localparam logic [15:0] RST_SCALE_XZ     = 16'd256;

	typedef enum logic [1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_MAX_HEIGHT   = 2'd2,
		CFG_SCALE_XZ     = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		MODE_DIV  = 1'b0,
		MODE_SQRT = 1'b1
	} step_mode_t;

endpackage

// File: rtl/hvn_ram.sv
`timescale 1ns / 1ps
module hvn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/hvn_step.sv
`timescale 1ns / 1ps
module hvn_step import hvn_pkg::*; (
	input  step_mode_t    mode,
	input  logic [RW-1:0] rem,
	input  logic [1:0]    bits,
	input  logic [QW-1:0] quo,
	input  logic [DW-1:0] dvs,
	output logic [RW-1:0] rem_nxt,
	output logic          qbit
);

	logic [RW+1:0] r2;
	logic [RW+1:0] trial;

	always_comb begin
		case (mode)
			MODE_SQRT: begin
				r2    = {rem, bits};
				trial = (RW+2)'({quo, 2'b01});
			end
			MODE_DIV: begin
				r2    = {1'b0, rem, bits[1]};
				trial = (RW+2)'(dvs);
			end
			default: begin
				r2    = '0;
				trial = '0;
			end
		endcase
		qbit    = (r2 >= trial);
		rem_nxt = qbit ? RW'(r2 - trial) : RW'(r2);
	end

endmodule

// File: rtl/heightmap_vertex_normal_stream.sv
// A request is taken only while the block is idle, so a new request waits until the
//   last vertex has left the finish state; the shared compare-subtract unit runs a
//   26-step square root and six 15/16-step divisions back to back.
// A first-row sample only updates the line stores; a request past the image yields nothing.
// Reset clears counters, control, configuration and output registers; the datapath
//   registers and the line stores are not cleared and hold garbage until written.
`timescale 1ns / 1ps
`include "heightmap_vertex_normal_stream_assert.svh"
module heightmap_vertex_normal_stream import hvn_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic [7:0]         height_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [11:0]        column,
	output logic [11:0]        row,
	output logic [27:0]        pos_x,
	output logic [15:0]        pos_y,
	output logic [27:0]        pos_z,
	output logic signed [15:0] normal_x,
	output logic [14:0]        normal_y,
	output logic signed [15:0] normal_z,
	output logic [15:0]        tex_u,
	output logic [15:0]        tex_v,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int RIW = $clog2(MAX_HEIGHT);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_RDA, ST_RDB, ST_RDC, ST_RDD,
		ST_MAX, ST_MAZ, ST_MAY, ST_MSX, ST_MSY, ST_MSZ, ST_MPX, ST_MPZ, ST_MPY,
		ST_LOAD, ST_RUN, ST_STORE, ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		OP_SQRT, OP_NX, OP_NY, OP_NZ, OP_TU, OP_TV, OP_PY
	} op_t;

	state_t state_q;
	op_t    op_q;

	logic [12:0] image_width_q;
	logic [12:0] image_height_q;
	logic [15:0] max_height_q;
	logic [15:0] scale_xz_q;

	logic [CW-1:0]  in_column_q;
	logic [HW-1:0]  in_row_q;
	logic [WW-1:0]  drain_column_q;
	logic [WW-1:0]  w_eff;
	logic [HW-1:0]  h_eff;
	logic [CW-1:0]  c_sel;
	logic           in_acc;
	logic           sample_go;
	logic           drain_go;

	logic [CW-1:0]  col_q;
	logic [RIW-1:0] row_q;
	logic           drain_q;
	logic           emit_q;
	logic           left_en_q;
	logic           right_en_q;
	logic           north_en_q;
	logic [7:0]     centre_q;
	logic [7:0]     left_q;
	logic [7:0]     right_q;
	logic [7:0]     north_q;
	logic [7:0]     south_q;
	logic           neg_x_q;
	logic           neg_z_q;
	logic [7:0]     dx_mag;
	logic [7:0]     dz_mag;

	logic [MW-1:0]  mul_a;
	logic [MW-1:0]  mul_b;
	logic [PW-1:0]  prod_q;
	logic [MW-1:0]  ax_q;
	logic [MW-1:0]  ay_q;
	logic [MW-1:0]  az_q;
	logic [SW-1:0]  sum_q;
	logic [27:0]    posx_q;
	logic [27:0]    posz_q;

	logic [RW-1:0]   rem_q;
	logic [SW-1:0]   src_q;
	logic [QW-1:0]   quo_q;
	logic [DW-1:0]   dvs_q;
	step_mode_t      mode_q;
	logic [CNTW-1:0] cnt_q;
	logic [QW-1:0]   len_q;
	logic [14:0]     nxq_q;
	logic [14:0]     nyq_q;
	logic [14:0]     nzq_q;
	logic [15:0]     tu_q;
	logic [15:0]     tv_q;
	logic [15:0]     py_q;

	logic [NW-1:0]   ld_n;
	logic [DW-1:0]   ld_d;
	logic [4:0]      ld_qb;
	step_mode_t      ld_mode;
	logic [5:0]      ld_shift;
	logic [RW-1:0]   step_rem;
	logic            step_bit;

	logic           prev_we;
	logic [CW-1:0]  prev_raddr;
	logic [7:0]     prev_rdata;
	logic [CW-1:0]  older_raddr;
	logic [7:0]     older_rdata;
	logic [15:0]    nx_mag;
	logic [15:0]    nz_mag;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;

	always_comb begin
		if (image_width_q < 13'd2) begin
			w_eff = WW'(2);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(image_width_q);
		end
		if (image_height_q < 13'd2) begin
			h_eff = HW'(2);
		end else if (32'(image_height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(image_height_q);
		end
	end

	assign c_sel     = (WW'(in_column_q) >= w_eff) ? CW'(w_eff - 1'b1) : in_column_q;
	assign sample_go = in_acc && !func && (in_row_q < h_eff);
	assign drain_go  = in_acc && func && (in_row_q >= h_eff) && (drain_column_q < w_eff);

	assign dx_mag = (left_q < right_q) ? (right_q - left_q) : (left_q - right_q);
	assign dz_mag = neg_z_q ? (south_q - north_q) : (north_q - south_q);

	// line stores
	always_comb begin
		prev_raddr  = col_q;
		older_raddr = col_q;
		case (state_q)
			ST_RDB: begin
				prev_raddr  = CW'(col_q + 1'b1);
				older_raddr = CW'(col_q - 1'b1);
			end
			ST_RDC: prev_raddr = CW'(col_q - 1'b1);
			default: ;
		endcase
	end

	assign prev_we = (state_q == ST_RDB) && !drain_q;

	hvn_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_prev_row (
		.clk   (clk),
		.we    (prev_we),
		.waddr (col_q),
		.wdata (south_q),
		.raddr (prev_raddr),
		.rdata (prev_rdata)
	);

	hvn_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_older_row (
		.clk   (clk),
		.we    (prev_we),
		.waddr (col_q),
		.wdata (prev_rdata),
		.raddr (older_raddr),
		.rdata (older_rdata)
	);

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MAX: begin mul_a = MW'(dx_mag);     mul_b = MW'(max_height_q); end
			ST_MAZ: begin mul_a = MW'(dz_mag);     mul_b = MW'(max_height_q); end
			ST_MAY: begin mul_a = MW'(SCALE_Y);    mul_b = MW'(scale_xz_q);   end
			ST_MSX: begin mul_a = ax_q;            mul_b = ax_q;              end
			ST_MSY: begin mul_a = ay_q;            mul_b = ay_q;              end
			ST_MSZ: begin mul_a = az_q;            mul_b = az_q;              end
			ST_MPX: begin mul_a = MW'(col_q);      mul_b = MW'(scale_xz_q);   end
			ST_MPZ: begin mul_a = MW'(row_q);      mul_b = MW'(scale_xz_q);   end
			ST_MPY: begin mul_a = MW'(centre_q);   mul_b = MW'(max_height_q); end
			default: ;
		endcase
	end

	// operand setup for the shared step unit
	always_comb begin
		ld_n    = '0;
		ld_d    = '0;
		ld_qb   = 5'(WIDE_QB);
		ld_mode = MODE_DIV;
		case (op_q)
			OP_SQRT: ld_mode = MODE_SQRT;
			OP_NX: begin ld_n = NW'(ax_q) << NORM_SHIFT; ld_d = len_q; ld_qb = 5'(NORM_QB); end
			OP_NY: begin ld_n = NW'(ay_q) << NORM_SHIFT; ld_d = len_q; ld_qb = 5'(NORM_QB); end
			OP_NZ: begin ld_n = NW'(az_q) << NORM_SHIFT; ld_d = len_q; ld_qb = 5'(NORM_QB); end
			OP_TU: begin ld_n = NW'(col_q) << TEX_SHIFT; ld_d = DW'(w_eff - 1'b1); end
			OP_TV: begin ld_n = NW'(row_q) << TEX_SHIFT; ld_d = DW'(h_eff - 1'b1); end
			OP_PY: begin ld_n = NW'(prod_q); ld_d = DW'(HEIGHT_DIV); end
			default: ;
		endcase
		ld_shift = 6'(SW) - 6'(ld_qb);
	end

	hvn_step u_step (
		.mode    (mode_q),
		.rem     (rem_q),
		.bits    (src_q[SW-1 -: 2]),
		.quo     (quo_q),
		.dvs     (dvs_q),
		.rem_nxt (step_rem),
		.qbit    (step_bit)
	);

	assign nx_mag = 16'(nxq_q);
	assign nz_mag = 16'(nzq_q);

	// sequencer, counters, configuration and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			op_q           <= OP_SQRT;
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
			max_height_q   <= RST_MAX_HEIGHT;
			scale_xz_q     <= RST_SCALE_XZ;
			in_column_q    <= '0;
			in_row_q       <= '0;
			drain_column_q <= '0;
			cnt_q          <= '0;
			out_valid      <= 1'b0;
			column         <= '0;
			row            <= '0;
			pos_x          <= '0;
			pos_y          <= '0;
			pos_z          <= '0;
			normal_x       <= '0;
			normal_y       <= '0;
			normal_z       <= '0;
			tex_u          <= '0;
			tex_v          <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[12:0];
					CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[12:0];
					CFG_MAX_HEIGHT:   max_height_q   <= cfg_data;
					CFG_SCALE_XZ:     scale_xz_q     <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready && state_q != ST_FIN) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample_go) begin
						if (WW'(c_sel) + 1'b1 >= w_eff) begin
							in_column_q <= '0;
							in_row_q    <= in_row_q + 1'b1;
						end else begin
							in_column_q <= c_sel + 1'b1;
						end
						state_q <= ST_RDA;
					end else if (drain_go) begin
						drain_column_q <= drain_column_q + 1'b1;
						state_q        <= ST_RDA;
					end
				end
				ST_RDA: state_q <= ST_RDB;
				ST_RDB: state_q <= emit_q ? ST_RDC : ST_IDLE;
				ST_RDC: state_q <= drain_q ? ST_RDD : ST_MAX;
				ST_RDD: state_q <= ST_MAX;
				ST_MAX: state_q <= ST_MAZ;
				ST_MAZ: state_q <= ST_MAY;
				ST_MAY: state_q <= ST_MSX;
				ST_MSX: state_q <= ST_MSY;
				ST_MSY: state_q <= ST_MSZ;
				ST_MSZ: state_q <= ST_MPX;
				ST_MPX: state_q <= ST_MPZ;
				ST_MPZ: state_q <= ST_MPY;
				ST_MPY: begin
					op_q    <= OP_SQRT;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					cnt_q   <= (ld_mode == MODE_SQRT) ? CNTW'(SQRT_STEPS) : ld_qb;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNTW'(1)) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					case (op_q)
						OP_SQRT: begin op_q <= OP_NX; state_q <= ST_LOAD; end
						OP_NX:   begin op_q <= OP_NY; state_q <= ST_LOAD; end
						OP_NY:   begin op_q <= OP_NZ; state_q <= ST_LOAD; end
						OP_NZ:   begin op_q <= OP_TU; state_q <= ST_LOAD; end
						OP_TU:   begin op_q <= OP_TV; state_q <= ST_LOAD; end
						OP_TV:   begin op_q <= OP_PY; state_q <= ST_LOAD; end
						OP_PY:   state_q <= ST_FIN;
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_FIN: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						column    <= 12'(col_q);
						row       <= 12'(row_q);
						pos_x     <= posx_q;
						pos_z     <= posz_q;
						pos_y     <= py_q;
						tex_u     <= tu_q;
						tex_v     <= tv_q;
						if (len_q == '0) begin
							normal_x <= '0;
							normal_y <= NORM_ONE;
							normal_z <= '0;
						end else begin
							normal_x <= neg_x_q ? (16'd0 - nx_mag) : nx_mag;
							normal_y <= nyq_q;
							normal_z <= neg_z_q ? (16'd0 - nz_mag) : nz_mag;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (sample_go) begin
					col_q      <= c_sel;
					row_q      <= RIW'(in_row_q - 1'b1);
					south_q    <= height_sample;
					drain_q    <= 1'b0;
					emit_q     <= (in_row_q != '0);
					north_en_q <= (in_row_q >= HW'(2));
					left_en_q  <= (c_sel != '0);
					right_en_q <= (WW'(c_sel) + 1'b1 < w_eff);
				end else if (drain_go) begin
					col_q      <= CW'(drain_column_q);
					row_q      <= RIW'(h_eff - 1'b1);
					south_q    <= '0;
					drain_q    <= 1'b1;
					emit_q     <= 1'b1;
					north_en_q <= 1'b1;
					left_en_q  <= (drain_column_q != '0);
					right_en_q <= (drain_column_q + 1'b1 < w_eff);
				end
			end
			ST_RDB: begin
				centre_q <= prev_rdata;
				north_q  <= north_en_q ? older_rdata : 8'd0;
			end
			ST_RDC: begin
				right_q <= right_en_q ? prev_rdata : 8'd0;
				left_q  <= left_en_q ? older_rdata : 8'd0;
			end
			ST_RDD: left_q <= left_en_q ? prev_rdata : 8'd0;
			ST_MAX: begin
				neg_x_q <= (left_q < right_q);
				neg_z_q <= (north_q < south_q);
			end
			ST_MAZ: ax_q <= MW'(prod_q);
			ST_MAY: az_q <= MW'(prod_q);
			ST_MSX: ay_q <= MW'(prod_q);
			ST_MSY: sum_q <= SW'(prod_q);
			ST_MSZ: sum_q <= sum_q + SW'(prod_q);
			ST_MPX: sum_q <= sum_q + SW'(prod_q);
			ST_MPZ: posx_q <= 28'(prod_q);
			ST_MPY: posz_q <= 28'(prod_q);
			ST_LOAD: begin
				quo_q  <= '0;
				dvs_q  <= ld_d;
				mode_q <= ld_mode;
				if (ld_mode == MODE_SQRT) begin
					rem_q <= '0;
					src_q <= sum_q;
				end else begin
					rem_q <= RW'(ld_n >> ld_qb);
					src_q <= SW'(ld_n) << ld_shift;
				end
			end
			ST_RUN: begin
				rem_q <= step_rem;
				quo_q <= {quo_q[QW-2:0], step_bit};
				src_q <= (mode_q == MODE_SQRT) ? (src_q << 2) : (src_q << 1);
			end
			ST_STORE: begin
				case (op_q)
					OP_SQRT: len_q <= quo_q;
					OP_NX:   nxq_q <= 15'(quo_q);
					OP_NY:   nyq_q <= 15'(quo_q);
					OP_NZ:   nzq_q <= 15'(quo_q);
					OP_TU:   tu_q  <= 16'(quo_q);
					OP_TV:   tv_q  <= 16'(quo_q);
					OP_PY:   py_q  <= 16'(quo_q);
					default: ;
				endcase
			end
			default: ;
		endcase
		case (state_q)
			ST_MAX, ST_MAZ, ST_MAY, ST_MSX, ST_MSY, ST_MSZ, ST_MPX, ST_MPZ, ST_MPY:
				prod_q <= mul_a * mul_b;
			default: ;
		endcase
	end

	`HVN_ASSERT(a_run_count, state_q == ST_RUN |-> cnt_q != '0, "step counter empty in run")
	`HVN_ASSERT(a_out_from_fin, $rose(out_valid) |-> $past(state_q) == ST_FIN, "result without finish")
	`HVN_ASSERT(a_fin_hold, state_q == ST_FIN && out_valid && !out_ready |=> state_q == ST_FIN, "finished vertex dropped")
	`HVN_NEVER(a_fin_no_emit, state_q == ST_FIN && !emit_q, "finish on a request without result")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import hvn_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE = 200;

	typedef struct packed {
		logic [11:0] column;
		logic [11:0] row;
		logic [27:0] pos_x;
		logic [15:0] pos_y;
		logic [27:0] pos_z;
		logic [15:0] normal_x;
		logic [14:0] normal_y;
		logic [15:0] normal_z;
		logic [15:0] tex_u;
		logic [15:0] tex_v;
	} vertex_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic func;
	logic [7:0] height_sample;
	logic out_valid;
	logic out_ready;
	logic [11:0] column;
	logic [11:0] row;
	logic [27:0] pos_x;
	logic [15:0] pos_y;
	logic [27:0] pos_z;
	logic signed [15:0] normal_x;
	logic [14:0] normal_y;
	logic signed [15:0] normal_z;
	logic [15:0] tex_u;
	logic [15:0] tex_v;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	heightmap_vertex_normal_stream u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .height_sample(height_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.column(column), .row(row), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.tex_u(tex_u), .tex_v(tex_v),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the block
	logic [12:0] sh_width, sh_height;
	logic [15:0] sh_max_height, sh_scale;
	logic [7:0] prev_line [4096];
	logic [7:0] older_line [4096];
	int unsigned cur_col, cur_row, drain_col;

	vertex_t vertex_q [$];
	int errors = 0;
	int checked = 0;
	int sent = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int img_w;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int unsigned width_used();
		if (sh_width < 2) return 2;
		if (sh_width > 4096) return 4096;
		return sh_width;
	endfunction

	function automatic int unsigned height_used();
		if (sh_height < 2) return 2;
		if (sh_height > 4096) return 4096;
		return sh_height;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] unit_comp(longint unsigned mag, bit neg,
			longint unsigned len);
		longint unsigned q;
		q = (mag * 16384) / len;
		if (neg) q = (64'd0 - q);
		return q[15:0];
	endfunction

	function automatic vertex_t make_vertex(int unsigned c, int unsigned r,
			int unsigned centre, int unsigned lft, int unsigned rgt,
			int unsigned north, int unsigned south, int unsigned w, int unsigned h);
		vertex_t v;
		longint unsigned mh, sc, ax, ay, az, len, t;
		bit nx, nz;
		mh = sh_max_height;
		sc = sh_scale;
		nx = lft < rgt;
		nz = north < south;
		ax = (nx ? rgt - lft : lft - rgt) * mh;
		az = (nz ? south - north : north - south) * mh;
		ay = 510 * sc;
		len = int_sqrt(ax * ax + ay * ay + az * az);
		v.column = c[11:0];
		v.row = r[11:0];
		t = c * sc;
		v.pos_x = t[27:0];
		t = (centre * mh) / 255;
		v.pos_y = t[15:0];
		t = r * sc;
		v.pos_z = t[27:0];
		if (len == 0) begin
			v.normal_x = 16'd0;
			v.normal_y = NORM_ONE;
			v.normal_z = 16'd0;
		end else begin
			v.normal_x = unit_comp(ax, nx, len);
			v.normal_y = 15'(unit_comp(ay, 1'b0, len));
			v.normal_z = unit_comp(az, nz, len);
		end
		t = (longint'(c) * 32768) / (w - 1);
		v.tex_u = t[15:0];
		t = (longint'(r) * 32768) / (h - 1);
		v.tex_v = t[15:0];
		return v;
	endfunction

	task automatic predict_vertex(bit f, logic [7:0] s);
		int unsigned w, h, c, d, lft, rgt, north;
		w = width_used();
		h = height_used();
		if (!f) begin
			if (cur_row >= h) return;
			c = cur_col;
			if (c >= w) c = w - 1;
			if (cur_row >= 1) begin
				lft = c > 0 ? older_line[c - 1] : 0;
				rgt = (c + 1 < w) ? prev_line[c + 1] : 0;
				north = cur_row >= 2 ? older_line[c] : 0;
				vertex_q = {vertex_q, make_vertex(c, cur_row - 1, prev_line[c], lft, rgt,
					north, s, w, h)};
			end
			older_line[c] = prev_line[c];
			prev_line[c] = s;
			if (c + 1 >= w) begin
				cur_col = 0;
				cur_row++;
			end else begin
				cur_col = c + 1;
			end
		end else begin
			d = drain_col;
			if (cur_row < h || d >= w) return;
			lft = d > 0 ? prev_line[d - 1] : 0;
			rgt = (d + 1 < w) ? prev_line[d + 1] : 0;
			vertex_q = {vertex_q, make_vertex(d, h - 1, prev_line[d], lft, rgt,
				older_line[d], 0, w, h)};
			drain_col = d + 1;
		end
	endtask

	task automatic report_mismatch(string field, logic [27:0] got, logic [27:0] want);
		errors++;
		$display("mismatch %s at vertex %0d: got %0h want %0h", field, checked, got, want);
	endtask

	always @(posedge clk) begin
		vertex_t w;
		if (arst_n && out_valid && out_ready) begin
			if (vertex_q.size() == 0) begin
				report_mismatch("unexpected vertex column", 28'(column), 28'd0);
			end else begin
				w = vertex_q.pop_front();
				if (column !== w.column) report_mismatch("column", column, w.column);
				if (row !== w.row) report_mismatch("row", row, w.row);
				if (pos_x !== w.pos_x) report_mismatch("pos_x", pos_x, w.pos_x);
				if (pos_y !== w.pos_y) report_mismatch("pos_y", pos_y, w.pos_y);
				if (pos_z !== w.pos_z) report_mismatch("pos_z", pos_z, w.pos_z);
				if (normal_x !== w.normal_x) report_mismatch("normal_x", normal_x, w.normal_x);
				if (normal_y !== w.normal_y) report_mismatch("normal_y", normal_y, w.normal_y);
				if (normal_z !== w.normal_z) report_mismatch("normal_z", normal_z, w.normal_z);
				if (tex_u !== w.tex_u) report_mismatch("tex_u", tex_u, w.tex_u);
				if (tex_v !== w.tex_v) report_mismatch("tex_v", tex_v, w.tex_v);
				checked++;
			end
		end
	end

	// hold off on request of a test, else stall at random
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_item(bit f, logic [7:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		height_sample <= s;
		do @(posedge clk); while (!in_ready);
		sent++;
		predict_vertex(f, s);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (vertex_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_IMAGE_WIDTH: sh_width = val[12:0];
			CFG_IMAGE_HEIGHT: sh_height = val[12:0];
			CFG_MAX_HEIGHT: sh_max_height = val;
			CFG_SCALE_XZ: sh_scale = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_row(int drain_pct);
		for (int i = 0; i < img_w; i++) begin
			if ($urandom_range(99) < drain_pct) send_item(1'b1, 8'($urandom_range(255)));
			send_item(1'b0, 8'($urandom_range(255)));
		end
	endtask

	task automatic test_register_extremes();
		write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
		write_reg(CFG_IMAGE_WIDTH, 16'd0);
		write_reg(CFG_IMAGE_WIDTH, 16'd1);
		write_reg(CFG_IMAGE_HEIGHT, 16'd0);
		write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
		write_reg(CFG_MAX_HEIGHT, 16'hFFFF);
		write_reg(CFG_SCALE_XZ, 16'hFFFF);
		write_reg(CFG_IMAGE_WIDTH, 16'(img_w));
	endtask

	task automatic test_first_row();
		send_item(1'b1, 8'hFF);
		for (int i = 0; i < img_w; i++) send_item(1'b0, (i % 2) ? 8'hFF : 8'h00);
		send_item(1'b1, 8'h00);
		for (int i = 0; i < img_w; i++) send_item(1'b0, (i % 2) ? 8'h00 : 8'hFF);
		wait_idle();
	endtask

	task automatic test_flat_normal();
		write_reg(CFG_MAX_HEIGHT, 16'd0);
		write_reg(CFG_SCALE_XZ, 16'd0);
		for (int i = 0; i < img_w; i++) send_item(1'b0, 8'h80);
		wait_idle();
		write_reg(CFG_MAX_HEIGHT, 16'hFFFF);
		write_reg(CFG_SCALE_XZ, 16'd0);
		send_row(0);
		wait_idle();
	endtask

	task automatic test_past_image();
		write_reg(CFG_IMAGE_HEIGHT, 16'd1);
		for (int i = 0; i < 5; i++) send_item(1'b0, 8'($urandom_range(255)));
		wait_idle();
		write_reg(CFG_IMAGE_HEIGHT, 16'h1FFF);
	endtask

	task automatic test_random_rows();
		int rows;
		rows = 1000 / (img_w * 4) + 1;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 86; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 86; end
				default: begin send_idle_pct = 35; stall_pct = 35; end
			endcase
			for (int r = 0; r < rows; r++) begin
				if ($urandom_range(9) == 0) begin
					wait_idle();
					write_reg(CFG_MAX_HEIGHT, 16'($urandom));
					write_reg(CFG_SCALE_XZ,
						16'($urandom_range(3) == 0 ? $urandom : $urandom_range(1023)));
					write_reg(CFG_IMAGE_HEIGHT, 16'(200 + $urandom_range(7991)));
				end
				send_row(8);
			end
		end
		wait_idle();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left = 3000;
		send_row(0);
		send_row(0);
		in_valid <= 1'b0;
		do @(posedge clk); while (vertex_q.size() != 0);
		send_row(0);
		wait_idle();
	endtask

	task automatic test_drain();
		write_reg(CFG_IMAGE_HEIGHT, 16'(cur_row));
		send_idle_pct = 35;
		stall_pct = 35;
		send_item(1'b0, 8'hFF);
		for (int i = 0; i < img_w + 3; i++) begin
			send_item(1'b1, 8'($urandom_range(255)));
			if ($urandom_range(3) == 0) send_item(1'b0, 8'($urandom_range(255)));
		end
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = 1'b0;
		height_sample = 8'd0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data = 16'd0;
		sh_width = RST_IMAGE_WIDTH;
		sh_height = RST_IMAGE_HEIGHT;
		sh_max_height = RST_MAX_HEIGHT;
		sh_scale = RST_SCALE_XZ;
		for (int i = 0; i < 4096; i++) begin
			prev_line[i] = 8'd0;
			older_line[i] = 8'd0;
		end
		cur_col = 0;
		cur_row = 0;
		drain_col = 0;
		img_w = $urandom_range(8, 2);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_extremes();
		test_first_row();
		test_flat_normal();
		test_past_image();
		test_random_rows();
		test_backpressure();
		test_drain();
		$display("image of %0d columns by %0d rows, %0d requests, %0d vertices checked",
			img_w, cur_row, sent, checked);
		$display("covered register extremes, idle and stall phases, hold-off and drains");
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
